FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_RST(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/spr_pkg.sv
// Package for the sync pulse run detector: fixed widths, register indexes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

  localparam int AVG_WINDOW     = 8;
  localparam int SLOT_W         = $clog2(AVG_WINDOW);
  localparam int FILL_W         = SLOT_W + 1;
  localparam int SAMPLE_W       = 8;
  localparam int WSUM_W         = SAMPLE_W + SLOT_W;
  localparam int POS_OUT_W      = 32;
  localparam int THR_W          = 9;
  localparam int PLEN_W         = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 10;

  localparam int PULSE_LEN_MAX_DEF = 1023;
  localparam int POSITION_BITS_DEF = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DARK_THR   = 2'd0;
  localparam cfg_idx_t REG_BRIGHT_THR = 2'd1;
  localparam cfg_idx_t REG_MIN_LEN    = 2'd2;
  localparam cfg_idx_t REG_MAX_LEN    = 2'd3;

  localparam logic [THR_W-1:0]  DARK_THR_RST   = 9'd128;
  localparam logic [THR_W-1:0]  BRIGHT_THR_RST = 9'd192;
  localparam logic [PLEN_W-1:0] MIN_LEN_RST    = 10'd20;
  localparam logic [PLEN_W-1:0] MAX_LEN_RST    = 10'd100;

endpackage

FILE: rtl/core/sync_pulse_run_detector.sv
// Top level of the sync pulse run detector: moving average, dark/bright run tracking.
// Depends on spr_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// One sample in, one result out. One shared restoring divider makes one quotient
// bit per cycle. It produces the 8-bit average and then each run mean in turn.
// The input is not ready while a sample is in work. The result sits in an output
// register, so a new sample is taken while the previous result still waits. The
// run update of that new sample holds until the waiting result has left, so a
// stalled result side holds up that sample. Positions count from zero after
// reset and wrap at POSITION_BITS; reported positions are the low 32 bits.
// Configuration writes are taken at any time but belong in idle periods.
`include "assert_macros.svh"

module sync_pulse_run_detector
  import spr_pkg::*;
#(
  parameter int PULSE_LEN_MAX = PULSE_LEN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   smoothed_o,
  output logic                  dark_found_o,
  output logic [POS_OUT_W-1:0]  dark_start_pos_o,
  output logic [SAMPLE_W-1:0]   dark_mean_o,
  output logic                  bright_found_o,
  output logic [POS_OUT_W-1:0]  bright_end_pos_o,
  output logic [SAMPLE_W-1:0]   bright_mean_o
);

  localparam int LEN_W  = $clog2(PULSE_LEN_MAX + 1);
  localparam int SUM_W  = LEN_W + SAMPLE_W;
  localparam int CMP_W  = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
  localparam int STEP_W = $clog2(SAMPLE_W);
  localparam int PB     = POSITION_BITS;
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(PULSE_LEN_MAX);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_AVG, S_RUN, S_DMEAN, S_BMEAN, S_DONE
  } state_e;

  state_e               state_q;

  // configuration
  logic [THR_W-1:0]     dark_thr_q, bright_thr_q;
  logic [PLEN_W-1:0]    min_len_q, max_len_q;

  // moving-average window
  logic [SAMPLE_W-1:0]  win_q [AVG_WINDOW];
  logic [WSUM_W-1:0]    wsum_q;
  logic [FILL_W-1:0]    fill_q;
  logic [PB-1:0]        index_q, pos_q;

  // run trackers
  logic                 dk_active_q, br_active_q;
  logic [PB-1:0]        dk_start_q;
  logic [LEN_W-1:0]     dk_len_q, br_len_q;
  logic [SUM_W-1:0]     dk_sum_q, br_sum_q;
  logic [SUM_W-1:0]     br_num_q;
  logic [LEN_W-1:0]     br_den_q;

  // shared divider
  logic [SUM_W-1:0]     rem_q, dsr_q;
  logic [SAMPLE_W-1:0]  quo_q;
  logic [STEP_W-1:0]    step_q;

  logic [SAMPLE_W-1:0]  m_q;

  // output register
  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  smoothed_q, dk_mean_q, br_mean_q;
  logic                 dk_found_q, br_found_q;
  logic [POS_OUT_W-1:0] dk_pos_q, br_pos_q;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                 in_fire;
  logic [SLOT_W-1:0]    slot;
  logic                 win_full;
  logic [WSUM_W-1:0]    wsum_d;
  logic [FILL_W-1:0]    div_avg;
  logic [SUM_W-1:0]     rem_d;
  logic [SAMPLE_W-1:0]  quo_d;
  logic                 div_last;

  logic                 is_dark, is_bright;
  logic [LEN_W-1:0]     dk_blen, br_blen, dk_nlen, br_nlen;
  logic [SUM_W-1:0]     dk_bsum, br_bsum, dk_nsum, br_nsum;
  logic                 dk_qual, br_qual, dk_end, br_end;
  logic [PB+POS_OUT_W-1:0] dk_pos_ext, br_pos_ext;

  function automatic logic len_ok(input logic [LEN_W-1:0]  len,
                                  input logic [PLEN_W-1:0] lo,
                                  input logic [PLEN_W-1:0] hi);
    logic [CMP_W-1:0] l;
    l = CMP_W'(len);
    // a saturated counter never qualifies
    return (len != '0) && (len != LEN_MAX) && (l >= CMP_W'(lo)) && (l <= CMP_W'(hi));
  endfunction

  assign in_fire  = in_valid_i && in_ready_o;
  assign slot     = index_q[SLOT_W-1:0];
  assign win_full = (fill_q == FILL_W'(AVG_WINDOW));

  always_comb begin
    wsum_d = wsum_q + WSUM_W'(sample_i);
    if (win_full) begin
      wsum_d = wsum_d - WSUM_W'(win_q[slot]);
    end
    div_avg = (fill_q >= FILL_W'(AVG_WINDOW - 1)) ? FILL_W'(AVG_WINDOW) : fill_q + 1'b1;
  end

  // one restoring-division step
  always_comb begin
    if (rem_q >= dsr_q) begin
      rem_d = rem_q - dsr_q;
      quo_d = {quo_q[SAMPLE_W-2:0], 1'b1};
    end else begin
      rem_d = rem_q;
      quo_d = {quo_q[SAMPLE_W-2:0], 1'b0};
    end
    div_last = (step_q == STEP_LAST);
  end

  always_comb begin
    is_dark   = {1'b0, m_q} < dark_thr_q;
    is_bright = {1'b0, m_q} >= bright_thr_q;

    dk_blen = dk_active_q ? dk_len_q : '0;
    dk_bsum = dk_active_q ? dk_sum_q : '0;
    br_blen = br_active_q ? br_len_q : '0;
    br_bsum = br_active_q ? br_sum_q : '0;

    dk_nlen = (dk_blen == LEN_MAX) ? dk_blen : dk_blen + 1'b1;
    dk_nsum = (dk_blen == LEN_MAX) ? dk_bsum : dk_bsum + SUM_W'(m_q);
    br_nlen = (br_blen == LEN_MAX) ? br_blen : br_blen + 1'b1;
    br_nsum = (br_blen == LEN_MAX) ? br_bsum : br_bsum + SUM_W'(m_q);

    dk_qual = len_ok(dk_len_q, min_len_q, max_len_q);
    br_qual = len_ok(br_len_q, min_len_q, max_len_q);
    dk_end  = !is_dark && dk_active_q && dk_qual;
    br_end  = !is_bright && br_active_q && br_qual;

    dk_pos_ext = {{POS_OUT_W{1'b0}}, dk_start_q};
    br_pos_ext = {{POS_OUT_W{1'b0}}, pos_q};
  end

  // ---------------------------------------------------------------------------
  // Window storage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q[slot] <= sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, state and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dark_thr_q   <= DARK_THR_RST;
      bright_thr_q <= BRIGHT_THR_RST;
      min_len_q    <= MIN_LEN_RST;
      max_len_q    <= MAX_LEN_RST;
      wsum_q       <= '0;
      fill_q       <= '0;
      index_q      <= '0;
      pos_q        <= '0;
      dk_active_q  <= 1'b0;
      dk_start_q   <= '0;
      dk_len_q     <= '0;
      dk_sum_q     <= '0;
      br_active_q  <= 1'b0;
      br_len_q     <= '0;
      br_sum_q     <= '0;
      br_num_q     <= '0;
      br_den_q     <= '0;
      rem_q        <= '0;
      dsr_q        <= '0;
      quo_q        <= '0;
      step_q       <= '0;
      m_q          <= '0;
      out_valid_q  <= 1'b0;
      smoothed_q   <= '0;
      dk_found_q   <= 1'b0;
      dk_pos_q     <= '0;
      dk_mean_q    <= '0;
      br_found_q   <= 1'b0;
      br_pos_q     <= '0;
      br_mean_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DARK_THR:   dark_thr_q   <= THR_W'(cfg_wdata_i);
          REG_BRIGHT_THR: bright_thr_q <= THR_W'(cfg_wdata_i);
          REG_MIN_LEN:    min_len_q    <= cfg_wdata_i;
          REG_MAX_LEN:    max_len_q    <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            wsum_q  <= wsum_d;
            if (!win_full) begin
              fill_q <= fill_q + 1'b1;
            end
            pos_q   <= index_q;
            index_q <= index_q + 1'b1;
            rem_q   <= SUM_W'(wsum_d);
            dsr_q   <= SUM_W'({div_avg, {(SAMPLE_W-1){1'b0}}});
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= S_AVG;
          end
        end

        S_AVG: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          dsr_q  <= dsr_q >> 1;
          step_q <= step_q + 1'b1;
          if (div_last) begin
            m_q     <= quo_d;
            state_q <= S_RUN;
          end
        end

        S_RUN: begin
          // the output register is loaded here, so wait for the previous result to leave
          if (!out_valid_q || out_ready_i) begin
            // dark run
            if (is_dark) begin
              if (!dk_active_q) begin
                dk_start_q <= pos_q;
              end
              dk_active_q <= 1'b1;
              dk_len_q    <= dk_nlen;
              dk_sum_q    <= dk_nsum;
            end else if (dk_active_q) begin
              dk_active_q <= 1'b0;
              dk_len_q    <= '0;
              dk_sum_q    <= '0;
            end

            // bright run
            if (is_bright) begin
              br_active_q <= 1'b1;
              br_len_q    <= br_nlen;
              br_sum_q    <= br_nsum;
            end else if (br_active_q) begin
              br_active_q <= 1'b0;
              br_len_q    <= '0;
              br_sum_q    <= '0;
            end
            br_num_q <= br_sum_q;
            br_den_q <= br_len_q;

            smoothed_q <= m_q;
            dk_found_q <= dk_end;
            dk_pos_q   <= dk_end ? dk_pos_ext[POS_OUT_W-1:0] : '0;
            dk_mean_q  <= '0;
            br_found_q <= br_end;
            br_pos_q   <= br_end ? br_pos_ext[POS_OUT_W-1:0] : '0;
            br_mean_q  <= '0;

            quo_q  <= '0;
            step_q <= '0;
            if (dk_end) begin
              rem_q   <= dk_sum_q;
              dsr_q   <= {1'b0, dk_len_q, {(SAMPLE_W-1){1'b0}}};
              state_q <= S_DMEAN;
            end else if (br_end) begin
              rem_q   <= br_sum_q;
              dsr_q   <= {1'b0, br_len_q, {(SAMPLE_W-1){1'b0}}};
              state_q <= S_BMEAN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end

        S_DMEAN: begin
          if (div_last) begin
            dk_mean_q <= quo_d;
            quo_q     <= '0;
            step_q    <= '0;
            if (br_found_q) begin
              rem_q   <= br_num_q;
              dsr_q   <= {1'b0, br_den_q, {(SAMPLE_W-1){1'b0}}};
              state_q <= S_BMEAN;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            rem_q  <= rem_d;
            quo_q  <= quo_d;
            dsr_q  <= dsr_q >> 1;
            step_q <= step_q + 1'b1;
          end
        end

        S_BMEAN: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          dsr_q  <= dsr_q >> 1;
          step_q <= step_q + 1'b1;
          if (div_last) begin
            br_mean_q <= quo_d;
            state_q   <= S_DONE;
          end
        end

        S_DONE: begin
          // hand the finished result to the output register once it is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a new transaction is taken whenever the sequencer is idle; S_RUN holds off
  // loading the output register until the previous result has left
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign smoothed_o       = smoothed_q;
  assign dark_found_o     = dk_found_q;
  assign dark_start_pos_o = dk_pos_q;
  assign dark_mean_o      = dk_mean_q;
  assign bright_found_o   = br_found_q;
  assign bright_end_pos_o = br_pos_q;
  assign bright_mean_o    = br_mean_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_RST(a_accept_starts_avg, clk_i, rst_ni, in_fire |=> (state_q == S_AVG), "accepted sample did not start averaging")
  `ASSERT_IMPLIES(a_dark_idle_clear, clk_i, rst_ni, !dk_active_q, (dk_len_q == '0) && (dk_sum_q == '0), "idle dark run holds length or sum")
  `ASSERT_IMPLIES(a_bright_idle_clear, clk_i, rst_ni, !br_active_q, (br_len_q == '0) && (br_sum_q == '0), "idle bright run holds length or sum")
  `ASSERT_IMPLIES(a_idle_step_zero, clk_i, rst_ni, in_ready_o, step_q == '0, "divider step count not reset in idle")

endmodule

FILE: sim/sync_pulse_run_detector_test.sv
// Self-checking testbench for sync_pulse_run_detector: random and directed envelope
// samples, a scoreboard that tracks the moving average and dark/bright runs.
// Depends on spr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module sync_pulse_run_detector_test;
  import spr_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LEN_SATURATE  = PULSE_LEN_MAX_DEF;
  localparam int HOLD_CYCLES   = 200;

  typedef enum {STIM_RUNS, STIM_NOISE} stim_style_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  smoothed;
    logic                 dark_found;
    logic [POS_OUT_W-1:0] dark_start_pos;
    logic [SAMPLE_W-1:0]  dark_mean;
    logic                 bright_found;
    logic [POS_OUT_W-1:0] bright_end_pos;
    logic [SAMPLE_W-1:0]  bright_mean;
  } run_result_t;

  class pulse_run_scoreboard;
    logic [THR_W-1:0]    dark_thr;
    logic [THR_W-1:0]    bright_thr;
    logic [PLEN_W-1:0]   min_len;
    logic [PLEN_W-1:0]   max_len;
    logic [SAMPLE_W-1:0] window [AVG_WINDOW];
    logic [WSUM_W-1:0]   window_sum;
    int unsigned         fill;
    logic [31:0]         position;
    bit                  dark_on;
    logic [31:0]         dark_start;
    logic [PLEN_W-1:0]   dark_len;
    logic [17:0]         dark_sum;
    bit                  bright_on;
    logic [PLEN_W-1:0]   bright_len;
    logic [17:0]         bright_sum;
    run_result_t         expected_q [$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      dark_thr     = DARK_THR_RST;
      bright_thr   = BRIGHT_THR_RST;
      min_len      = MIN_LEN_RST;
      max_len      = MAX_LEN_RST;
      window_sum   = '0;
      fill         = 0;
      position     = '0;
      dark_on      = 0;
      dark_start   = '0;
      dark_len     = '0;
      dark_sum     = '0;
      bright_on    = 0;
      bright_len   = '0;
      bright_sum   = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DARK_THR:   dark_thr = data[THR_W-1:0];
        REG_BRIGHT_THR: bright_thr = data[THR_W-1:0];
        REG_MIN_LEN:    min_len = data[PLEN_W-1:0];
        REG_MAX_LEN:    max_len = data[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // a saturated run is never reported, even with max_len at the ceiling
    function bit run_qualifies(logic [PLEN_W-1:0] len);
      return len != 0 && len != LEN_SATURATE && len >= min_len && len <= max_len;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] level);
      run_result_t         r;
      int unsigned         slot;
      int unsigned         divisor;
      int unsigned         sum;
      logic [SAMPLE_W-1:0] avg;
      slot = position[SLOT_W-1:0];
      sum = window_sum + level;
      if (fill >= AVG_WINDOW) sum = sum - window[slot];
      window_sum = sum;
      window[slot] = level;
      divisor = (fill >= AVG_WINDOW - 1) ? AVG_WINDOW : fill + 1;
      if (fill < AVG_WINDOW) fill++;
      avg = sum / divisor;
      r = '0;
      r.smoothed = avg;

      if (avg < dark_thr) begin
        if (!dark_on) begin
          dark_on = 1;
          dark_start = position;
          dark_len = '0;
          dark_sum = '0;
        end
        if (dark_len != LEN_SATURATE) begin
          dark_len++;
          dark_sum += avg;
        end
      end else if (dark_on) begin
        if (run_qualifies(dark_len)) begin
          r.dark_found = 1'b1;
          r.dark_start_pos = dark_start;
          r.dark_mean = dark_sum / dark_len;
        end
        dark_on = 0;
        dark_len = '0;
        dark_sum = '0;
      end

      if (avg >= bright_thr) begin
        if (!bright_on) begin
          bright_on = 1;
          bright_len = '0;
          bright_sum = '0;
        end
        if (bright_len != LEN_SATURATE) begin
          bright_len++;
          bright_sum += avg;
        end
      end else if (bright_on) begin
        if (run_qualifies(bright_len)) begin
          r.bright_found = 1'b1;
          r.bright_end_pos = position;
          r.bright_mean = bright_sum / bright_len;
        end
        bright_on = 0;
        bright_len = '0;
        bright_sum = '0;
      end

      position++;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_result(run_result_t got);
      run_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result transaction with no sample pending");
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("smoothed", got.smoothed, want.smoothed);
      compare_field("dark_found", got.dark_found, want.dark_found);
      compare_field("dark_start_pos", got.dark_start_pos, want.dark_start_pos);
      compare_field("dark_mean", got.dark_mean, want.dark_mean);
      compare_field("bright_found", got.bright_found, want.bright_found);
      compare_field("bright_end_pos", got.bright_end_pos, want.bright_end_pos);
      compare_field("bright_mean", got.bright_mean, want.bright_mean);
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SAMPLE_W-1:0]   smoothed_o;
  logic                  dark_found_o;
  logic [POS_OUT_W-1:0]  dark_start_pos_o;
  logic [SAMPLE_W-1:0]   dark_mean_o;
  logic                  bright_found_o;
  logic [POS_OUT_W-1:0]  bright_end_pos_o;
  logic [SAMPLE_W-1:0]   bright_mean_o;

  pulse_run_scoreboard sb = new();
  bit                  quiet = 0;

  sync_pulse_run_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .smoothed_o       (smoothed_o),
    .dark_found_o     (dark_found_o),
    .dark_start_pos_o (dark_start_pos_o),
    .dark_mean_o      (dark_mean_o),
    .bright_found_o   (bright_found_o),
    .bright_end_pos_o (bright_end_pos_o),
    .bright_mean_o    (bright_mean_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off early in the run.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned got;
    bit          held;
    stall_left = 0;
    got = 0;
    held = 0;
    forever begin
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!quiet && !held && got >= 40) begin
        held = 1;
        stall_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        sb.check_result('{smoothed: smoothed_o, dark_found: dark_found_o,
                          dark_start_pos: dark_start_pos_o, dark_mean: dark_mean_o,
                          bright_found: bright_found_o, bright_end_pos: bright_end_pos_o,
                          bright_mean: bright_mean_o});
        got++;
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] level);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= level;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_sample(level);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] dark_v, bright_v, min_v, max_v);
    logic [CFG_DATA_W-1:0] vals [4];
    cfg_idx_t              idx_list [4];
    vals = '{dark_v, bright_v, min_v, max_v};
    idx_list = '{REG_DARK_THR, REG_BRIGHT_THR, REG_MIN_LEN, REG_MAX_LEN};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx_list[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Runs style: segments of dark, bright, mid or full-range levels with random content,
  // so smoothed values cross the thresholds in runs of varied length.
  task automatic run_phase(int unsigned count, stim_style_e style);
    int unsigned         seg_left;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         pick;
    logic [SAMPLE_W-1:0] level;
    seg_left = 0;
    lo = 0;
    hi = 255;
    repeat (count) begin
      if (style == STIM_NOISE) begin
        level = $urandom_range(0, 255);
      end else begin
        if (seg_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            lo = 0;
            hi = $urandom_range(0, 120);
          end else if (pick < 8) begin
            lo = $urandom_range(140, 255);
            hi = 255;
          end else if (pick < 9) begin
            lo = 100;
            hi = 200;
          end else begin
            lo = 0;
            hi = 255;
          end
          seg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 110)
                                                 : $urandom_range(1, 25);
        end
        seg_left--;
        level = $urandom_range(lo, hi);
      end
      send_sample(level);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [SAMPLE_W-1:0]   opening [24];
    logic [CFG_DATA_W-1:0] min_r;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_DARK_THR;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, partial-window divisors, very short runs.
    program_regs(10'd128, 10'd192, 10'd1, 10'd3);
    opening = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd127, 8'd1};
    foreach (opening[i]) send_sample(opening[i]);
    in_valid_i <= 1'b0;
    settle();

    program_regs(10'd128, 10'd192, 10'd20, 10'd100);
    run_phase(100, STIM_RUNS);
    settle();

    // Everything dark and bright at once: both run counters saturate.
    program_regs(10'd256, 10'd0, 10'd0, 10'd1023);
    run_phase(1030, STIM_NOISE);
    settle();

    // Nothing dark or bright: the saturated runs end unreported.
    program_regs(10'd0, 10'd256, 10'd5, 10'd10);
    run_phase(30, STIM_RUNS);
    settle();

    // Crossed thresholds.
    program_regs(10'd200, 10'd60, 10'd3, 10'd40);
    run_phase(80, STIM_RUNS);
    settle();

    // Length bounds out of order: nothing qualifies.
    program_regs(10'd90, 10'd170, 10'd50, 10'd10);
    run_phase(40, STIM_RUNS);
    settle();

    repeat (2) begin
      min_r = $urandom_range(1, 30);
      program_regs({1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))},
                   {1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))},
                   min_r, 10'($urandom_range(min_r, 150)));
      run_phase(50, STIM_RUNS);
      settle();
    end

    quiet = 1;
    program_regs(10'd128, 10'd192, 10'd20, 10'd100);
    run_phase(60, STIM_RUNS);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
